// ----- design/met_pkg.sv -----
// Shared types for the multi-channel event timer: request and result payloads,
// request and result codes, controller states and controller/datapath bundles.
// No dependencies.
package met_pkg;

  localparam int unsigned NumTimersDef  = 8;
  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned MaskWidth     = 8;
  localparam int unsigned TickWidth     = 64;

  // request codes
  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_ARM    = 3'd1,
    REQ_DISARM = 3'd2,
    REQ_REARM  = 3'd3,
    REQ_READ   = 3'd4
  } req_type_e;

  // result codes
  typedef enum logic [2:0] {
    KIND_ARM_ACK   = 3'd0,
    KIND_DISARM    = 3'd1,
    KIND_REARM     = 3'd2,
    KIND_EXPIRY    = 3'd3,
    KIND_TICK_READ = 3'd4
  } kind_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  timer_id;
    logic [15:0] tick_value;
    logic [15:0] reload_value;
  } req_t;

  typedef struct packed {
    logic [2:0]           result_kind;
    logic [2:0]           result_timer;
    logic                 was_running;
    logic [15:0]          count_value;
    logic [TickWidth-1:0] tick_total;
    logic                 last_result;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic latch;      // take the input transfer into the request register
    logic rd_en;      // issue a timer table read
    logic rd_next;    // read address is the next timer of the sweep
    logic exec;       // act on the timer row just read
    logic step;       // advance the sweep index
    logic emit_done;  // load the tick done result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_known;   // incoming request code is a defined one
    logic is_tick;    // held request is a tick
    logic last_idx;   // sweep is at the last timer
    logic need_emit;  // current row produces a result
    logic out_busy;   // output register is full and not being taken
  } stat_t;

endpackage

// ----- design/met_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module met_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/met_ctrl.sv -----
// Controller state machine of the event timer: sequences table reads,
// row updates, the tick sweep and result loads.
// Depends on met_pkg.
module met_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  met_pkg::stat_t stat_i,
  output met_pkg::cmd_t  cmd_o
);
  import met_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && stat_i.in_known) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!(stat_i.need_emit && stat_i.out_busy)) begin
          if (!stat_i.is_tick) begin
            state_d = S_IDLE;
          end else if (stat_i.last_idx) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i && stat_i.in_known;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      S_EXEC: begin
        if (!(stat_i.need_emit && stat_i.out_busy)) begin
          cmd_o.exec = 1'b1;
          // overlap the next row read with this row's write back
          if (stat_i.is_tick && !stat_i.last_idx) begin
            cmd_o.step    = 1'b1;
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      S_DONE: begin
        cmd_o.emit_done = !stat_i.out_busy;
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- design/met_dp.sv -----
// Datapath of the event timer: request register, timer table with valid bits,
// tick counter, post enable mask and the output register.
// Depends on met_pkg and met_ram.
module met_dp #(
  parameter int unsigned NUM_TIMERS  = met_pkg::NumTimersDef,
  parameter int unsigned COUNT_WIDTH = met_pkg::CountWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  met_pkg::cmd_t                   cmd_i,
  output met_pkg::stat_t                  stat_o,
  input  met_pkg::req_t                   in_data_i,
  input  logic                            cfg_valid_i,
  input  logic [met_pkg::MaskWidth-1:0]   cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output met_pkg::rsp_t                   out_data_o
);
  import met_pkg::*;

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned ROW_W = 2 * COUNT_WIDTH;

  req_t                   req_q;
  logic                   ok_q;
  logic [IDX_W-1:0]       idx_q;
  logic [TickWidth-1:0]   tick_q;
  logic [MaskWidth-1:0]   mask_q;
  logic [NUM_TIMERS-1:0]  valid_q;
  logic                   rd_valid_q;
  logic                   out_valid_q;
  rsp_t                   out_q;

  logic                   in_ok;
  logic                   is_tick;
  logic [IDX_W-1:0]       raddr;
  logic [ROW_W-1:0]       rdata;
  logic                   wr_en;
  logic [ROW_W-1:0]       wdata;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] cur_rld;
  logic [COUNT_WIDTH-1:0] dec_cnt;
  logic [COUNT_WIDTH-1:0] tv;
  logic [COUNT_WIDTH-1:0] rv;
  logic                   running;
  logic                   post_hit;
  logic                   need_emit;
  logic                   out_busy;
  logic                   load;
  rsp_t                   exec_rsp;
  rsp_t                   done_rsp;

  assign in_ok   = 32'(in_data_i.timer_id) < NUM_TIMERS;
  assign is_tick = req_q.req_type == REQ_TICK;

  // request register and timer index
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= in_data_i;
      ok_q  <= in_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.latch) begin
      if (in_data_i.req_type == REQ_TICK || !in_ok) begin
        idx_q <= '0;
      end else begin
        idx_q <= IDX_W'(in_data_i.timer_id);
      end
    end else if (cmd_i.step) begin
      idx_q <= IDX_W'(idx_q + 1'b1);
    end
  end

  // tick counter, counted when the tick is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (cmd_i.latch && in_data_i.req_type == REQ_TICK) begin
      tick_q <= tick_q + 64'd1;
    end
  end

  // post enable mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_valid_i) begin
      mask_q <= cfg_data_i;
    end
  end

  // timer table: count in the low half, reload interval in the high half
  assign raddr = cmd_i.rd_next ? IDX_W'(idx_q + 1'b1) : idx_q;

  met_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_TIMERS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // rows never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[raddr];
      end
    end
  end

  assign cur_cnt  = rd_valid_q ? rdata[COUNT_WIDTH-1:0] : '0;
  assign cur_rld  = rd_valid_q ? rdata[ROW_W-1:COUNT_WIDTH] : '0;
  assign dec_cnt  = COUNT_WIDTH'(cur_cnt - 1'b1);
  assign tv       = COUNT_WIDTH'(req_q.tick_value);
  assign rv       = COUNT_WIDTH'(req_q.reload_value);
  assign running  = ok_q && (cur_cnt != '0);
  assign post_hit = (32'(idx_q) < MaskWidth) && mask_q[3'(idx_q)];

  // row update and result for the request in hand
  always_comb begin
    wr_en     = 1'b0;
    wdata     = {cur_rld, cur_cnt};
    need_emit = 1'b1;
    exec_rsp  = '0;
    exec_rsp.tick_total   = tick_q;
    exec_rsp.result_timer = req_q.timer_id;
    exec_rsp.last_result  = 1'b1;
    case (req_q.req_type)
      REQ_TICK: begin
        wr_en     = cmd_i.exec && (cur_cnt != '0);
        wdata     = (dec_cnt == '0) ? {cur_rld, cur_rld} : {cur_rld, dec_cnt};
        need_emit = (cur_cnt != '0) && (dec_cnt == '0) && post_hit;
        exec_rsp.result_kind  = KIND_EXPIRY;
        exec_rsp.result_timer = 3'(idx_q);
        exec_rsp.last_result  = 1'b0;
      end
      REQ_ARM: begin
        wr_en = cmd_i.exec && ok_q;
        wdata = {rv, tv};
        exec_rsp.result_kind = KIND_ARM_ACK;
      end
      REQ_DISARM: begin
        wr_en = cmd_i.exec && ok_q;
        wdata = {cur_rld, {COUNT_WIDTH{1'b0}}};
        exec_rsp.result_kind = KIND_DISARM;
        exec_rsp.was_running = running;
      end
      REQ_REARM: begin
        wr_en = cmd_i.exec && ok_q;
        wdata = {tv, tv};
        exec_rsp.result_kind = KIND_REARM;
        exec_rsp.was_running = running;
      end
      REQ_READ: begin
        exec_rsp.result_kind = KIND_TICK_READ;
        exec_rsp.count_value = ok_q ? 16'(cur_cnt) : 16'd0;
      end
      default: begin
        need_emit = 1'b0;
      end
    endcase
  end

  // tick done result
  always_comb begin
    done_rsp             = '0;
    done_rsp.result_kind = KIND_TICK_READ;
    done_rsp.tick_total  = tick_q;
    done_rsp.last_result = 1'b1;
  end

  // output register
  assign out_busy = out_valid_q && !out_ready_i;
  assign load     = (cmd_i.exec && need_emit) || cmd_i.emit_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cmd_i.emit_done ? done_rsp : exec_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status to the controller
  assign stat_o.in_known  = in_data_i.req_type == REQ_TICK   ||
                            in_data_i.req_type == REQ_ARM    ||
                            in_data_i.req_type == REQ_DISARM ||
                            in_data_i.req_type == REQ_REARM  ||
                            in_data_i.req_type == REQ_READ;
  assign stat_o.is_tick   = is_tick;
  assign stat_o.last_idx  = idx_q == IDX_W'(NUM_TIMERS - 1);
  assign stat_o.need_emit = need_emit;
  assign stat_o.out_busy  = out_busy;

endmodule

// ----- design/multi_channel_event_timer.sv -----
// Top level of the multi-channel event timer: controller and datapath.
// Depends on met_pkg, met_ctrl, met_dp and met_ram.
//
// A bank of NUM_TIMERS countdown timers kept in a small RAM, one row per timer
// holding its count and reload interval. Arm, disarm, rearm and read pass
// through the request register, a table read and the row update. A tick
// sweeps the table through its single read port, one timer per cycle while
// no result is held up, with the write back of one row overlapped with the
// read of the next. A result of any kind that is due while the output
// register is still full holds the request until the register is taken.
// The output register lets a finished result wait while the next request is
// taken. Request codes 5 to 7 are taken and dropped without a result. The post
// enable mask is written through its own channel, which is always ready.
module multi_channel_event_timer #(
  parameter int unsigned NUM_TIMERS  = met_pkg::NumTimersDef,
  parameter int unsigned COUNT_WIDTH = met_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  met_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output met_pkg::rsp_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [met_pkg::MaskWidth-1:0] cfg_data_i
);
  import met_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  // controller
  met_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  met_dp #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // a result is never loaded over one still waiting
  a_exec_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec && stat.need_emit |-> !stat.out_busy)
    else $error("row result loaded while output register busy");

  a_done_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_done |-> !stat.out_busy)
    else $error("tick done loaded while output register busy");

  // requests are only taken on an input transfer
  a_latch_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.latch |-> in_valid_i && in_ready_o)
    else $error("request latched without input transfer");

  // the sweep never reads past the last timer
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_next |-> stat.is_tick && !stat.last_idx)
    else $error("sweep read beyond last timer");

endmodule
